// ===== sv/tals_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tals_pkg
// Shared types, constants and functions of the tilt arrow LED matrix scanner.
// ----------------------------------------------------------------------------
package tals_pkg;

    localparam int ADC_BITS_DEF = 14;
    localparam int MAG_MAX_W    = 16;   // widest code difference (ADC_BITS max)
    localparam int GAIN_W       = 10;
    localparam int MID_W        = 14;
    localparam int PROD_W       = MAG_MAX_W + GAIN_W;
    localparam int Q_FRAC       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 14;
    localparam int JOB_Q_DEPTH  = 4;
    localparam int RES_Q_DEPTH  = 2;
    localparam int ROWS         = 8;
    localparam int COLS         = 8;
    localparam int ROW_W        = 3;
    localparam int TILT_W       = 4;
    localparam int TILT_MAX     = 7;

    localparam logic [MID_W-1:0]  MID_RST    = 14'd8133;
    localparam logic [GAIN_W-1:0] GAIN_X_RST = 10'd330;
    localparam logic [GAIN_W-1:0] GAIN_Y_RST = 10'd336;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MID_CODE = 2'd0,
        REG_GAIN_X   = 2'd1,
        REG_GAIN_Y   = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        DIR_FWD   = 3'd0,
        DIR_BACK  = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_RIGHT = 3'd3,
        DIR_STOP  = 3'd4,
        DIR_INIT  = 3'd5
    } dir_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                     is_sample;
        dir_t                     dir;
        logic signed [TILT_W-1:0] tilt_x;
        logic signed [TILT_W-1:0] tilt_y;
    } job_t;

    typedef struct packed {
        logic [ROWS-1:0]          row_drive;
        logic [COLS-1:0]          col_drive;
        dir_t                     direction;
        logic signed [TILT_W-1:0] tilt_x;
        logic signed [TILT_W-1:0] tilt_y;
    } result_t;

    // queue status seen by the neighbor of a queue
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [COLS-1:0] arrow_row(input dir_t d, input logic [ROW_W-1:0] r);
        logic [COLS-1:0] p;
        p = 8'hFF;
        unique case (d)
            DIR_FWD:
                case (r)
                    3'd0:    p = 8'h18;
                    3'd1:    p = 8'h3C;
                    3'd2:    p = 8'h7E;
                    3'd3:    p = 8'hFF;
                    default: p = 8'h3C;
                endcase
            DIR_BACK:
                case (r)
                    3'd4:    p = 8'hFF;
                    3'd5:    p = 8'h7E;
                    3'd6:    p = 8'h3C;
                    3'd7:    p = 8'h18;
                    default: p = 8'h3C;
                endcase
            DIR_LEFT:
                case (r)
                    3'd0, 3'd7: p = 8'h10;
                    3'd1, 3'd6: p = 8'h30;
                    3'd2, 3'd5: p = 8'h7F;
                    default:    p = 8'hFF;
                endcase
            DIR_RIGHT:
                case (r)
                    3'd0, 3'd7: p = 8'h08;
                    3'd1, 3'd6: p = 8'h0C;
                    3'd2, 3'd5: p = 8'hFE;
                    default:    p = 8'hFF;
                endcase
            DIR_STOP:
                case (r)
                    3'd0, 3'd7: p = 8'h3C;
                    3'd1, 3'd6: p = 8'h42;
                    3'd2:       p = 8'hA1;
                    3'd3:       p = 8'h91;
                    3'd4:       p = 8'h89;
                    default:    p = 8'h85;
                endcase
            default: p = 8'hFF;
        endcase
        return p;
    endfunction

    // Q16 product to clamped level; sign flips when neg differs from negate
    function automatic logic signed [TILT_W-1:0] tilt_level(
        input logic [PROD_W-1:0] prod,
        input logic              neg,
        input logic              negate
    );
        logic [PROD_W-Q_FRAC-1:0] whole;
        logic signed [TILT_W-1:0] lvl;
        whole = prod[PROD_W-1:Q_FRAC];
        if (whole > (PROD_W-Q_FRAC)'(TILT_MAX))
            lvl = TILT_W'(TILT_MAX);
        else
            lvl = {1'b0, whole[TILT_W-2:0]};
        if (neg != negate)
            lvl = -lvl;
        return lvl;
    endfunction

    function automatic dir_t choose_dir(
        input logic signed [TILT_W-1:0] x,
        input logic signed [TILT_W-1:0] y
    );
        logic signed [5:0] xs;
        logic signed [5:0] ys;
        dir_t d;
        xs = {{2{x[TILT_W-1]}}, x};
        ys = {{2{y[TILT_W-1]}}, y};
        if (xs > 6'sd0) begin
            if (ys > xs + 6'sd1)
                d = DIR_RIGHT;
            else if (-ys > xs + 6'sd1)
                d = DIR_LEFT;
            else
                d = DIR_FWD;
        end
        else if (xs < 6'sd0) begin
            if (ys > -(xs - 6'sd1))
                d = DIR_RIGHT;
            else if (ys < xs - 6'sd1)
                d = DIR_LEFT;
            else
                d = DIR_BACK;
        end
        else begin
            if (ys > 6'sd3)
                d = DIR_RIGHT;
            else if (ys < -6'sd3)
                d = DIR_LEFT;
            else
                d = DIR_STOP;
        end
        return d;
    endfunction

endpackage

// ===== sv/tals_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tals_fifo
// Small register queue; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module tals_fifo
    import tals_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output q_stat_t                    stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    // a full queue still takes an item when its head leaves in the same cycle
    assign do_rd = rd_en && (count_reg != '0);
    assign do_wr = wr_en && ((count_reg != CNT_W'(DEPTH)) || do_rd);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data    = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== sv/tals_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tals_front
// Takes items, holds the calibration registers, scales samples to tilt
// levels and picks the arrow direction; hands classified jobs to the queue.
// ----------------------------------------------------------------------------
module tals_front
    import tals_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         req_type,
    input  logic [ADC_BITS-1:0]          sample_a,
    input  logic [ADC_BITS-1:0]          sample_b,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic [$clog2(JOB_Q_DEPTH+1)-1:0] job_count,
    output logic                         job_wr,
    output job_t                         job
);

    localparam int CNT_W = $clog2(JOB_Q_DEPTH+1) + 1;

    logic [MID_W-1:0]     mid_reg;
    logic [GAIN_W-1:0]    gain_x_reg;
    logic [GAIN_W-1:0]    gain_y_reg;
    logic [ADC_BITS-1:0]  mid_eff;

    // stage 1: code differences
    logic                 v1_reg, s1_sample_reg;
    logic [ADC_BITS-1:0]  s1_mag_x_reg, s1_mag_y_reg;
    logic                 s1_neg_x_reg, s1_neg_y_reg;
    // stage 2: products
    logic                 v2_reg, s2_sample_reg;
    logic [PROD_W-1:0]    s2_prod_x_reg, s2_prod_y_reg;
    logic                 s2_neg_x_reg, s2_neg_y_reg;

    logic                 accept;
    logic                 neg_x, neg_y;
    logic [ADC_BITS-1:0]  mag_x, mag_y;
    logic [CNT_W-1:0]     in_flight;
    logic signed [TILT_W-1:0] lvl_x, lvl_y;

    generate
        if (ADC_BITS <= MID_W)
        begin : g_mid_narrow
            assign mid_eff = mid_reg[ADC_BITS-1:0];
        end
        else
        begin : g_mid_wide
            assign mid_eff = ADC_BITS'(mid_reg);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg    <= MID_RST;
            gain_x_reg <= GAIN_X_RST;
            gain_y_reg <= GAIN_Y_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MID_CODE: mid_reg    <= cfg_data[MID_W-1:0];
                REG_GAIN_X:   gain_x_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_Y:   gain_y_reg <= cfg_data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // every item in the pipe has a reserved queue slot
    assign in_flight = CNT_W'(v1_reg) + CNT_W'(v2_reg) + CNT_W'(job_count);
    assign full      = (in_flight >= CNT_W'(JOB_Q_DEPTH));
    assign accept    = push && !full;

    assign neg_x = (sample_b < mid_eff);
    assign neg_y = (sample_a < mid_eff);
    assign mag_x = neg_x ? (mid_eff - sample_b) : (sample_b - mid_eff);
    assign mag_y = neg_y ? (mid_eff - sample_a) : (sample_a - mid_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= req_type;
            s1_mag_x_reg  <= mag_x;
            s1_mag_y_reg  <= mag_y;
            s1_neg_x_reg  <= neg_x;
            s1_neg_y_reg  <= neg_y;
        end
        if (v1_reg)
        begin
            s2_sample_reg <= s1_sample_reg;
            s2_prod_x_reg <= PROD_W'(MAG_MAX_W'(s1_mag_x_reg) * gain_x_reg);
            s2_prod_y_reg <= PROD_W'(MAG_MAX_W'(s1_mag_y_reg) * gain_y_reg);
            s2_neg_x_reg  <= s1_neg_x_reg;
            s2_neg_y_reg  <= s1_neg_y_reg;
        end
    end

    assign lvl_x = tilt_level(s2_prod_x_reg, s2_neg_x_reg, 1'b0);
    assign lvl_y = tilt_level(s2_prod_y_reg, s2_neg_y_reg, 1'b1);

    assign job_wr        = v2_reg;
    assign job.is_sample = s2_sample_reg;
    assign job.dir       = choose_dir(lvl_x, lvl_y);
    assign job.tilt_x    = lvl_x;
    assign job.tilt_y    = lvl_y;

endmodule

// ===== sv/tals_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tals_back
// Carries out jobs in order: a sample loads an arrow into the frame store,
// a tick steps the row scan and drives the row and column lines.
// ----------------------------------------------------------------------------
module tals_back
    import tals_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_stat_t job_stat,
    input  job_t    job,
    output logic    job_rd,
    input  q_stat_t res_stat,
    input  logic    res_leaving,
    output logic    res_wr,
    output result_t res
);

    logic [COLS-1:0]  frame_reg [ROWS];
    logic [ROW_W-1:0] scan_row_reg, scan_row_next;
    dir_t             shown_dir_reg;
    logic [COLS-1:0]  pat;

    assign job_rd        = !job_stat.empty && (!res_stat.full || res_leaving);
    assign res_wr        = job_rd;
    assign scan_row_next = scan_row_reg + 1'b1;
    assign pat           = frame_reg[scan_row_next];

    always_comb
    begin
        res.tilt_x = '0;
        res.tilt_y = '0;
        if (job.is_sample)
        begin
            res.row_drive = '1;
            res.col_drive = '1;
            res.direction = job.dir;
            res.tilt_x    = job.tilt_x;
            res.tilt_y    = job.tilt_y;
        end
        else
        begin
            res.row_drive = ~(ROWS'(1) << scan_row_next);
            for (int c = 0; c < COLS; c++)
                res.col_drive[c] = ~pat[COLS-1-c];
            res.direction = shown_dir_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg  <= '0;
            shown_dir_reg <= DIR_INIT;
            for (int r = 0; r < ROWS; r++)
                frame_reg[r] <= '1;
        end
        else if (job_rd)
        begin
            if (job.is_sample)
            begin
                shown_dir_reg <= job.dir;
                for (int r = 0; r < ROWS; r++)
                    frame_reg[r] <= arrow_row(job.dir, ROW_W'(r));
            end
            else
            begin
                scan_row_reg <= scan_row_next;
            end
        end
    end

endmodule

// ===== sv/tilt_arrow_led_matrix_scanner_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_arrow_led_matrix_scanner_top
// Tilt arrow LED matrix scanner: accelerometer samples pick an arrow, scan
// ticks drive one matrix row at a time.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------
//   input    | push / full               | req_type, sample_a, sample_b
//   result   | empty / pop               | row_drive, col_drive, direction,
//            |                           | tilt_x, tilt_y
//   config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle sustained while full stays low and results are popped.
// The front pipe (difference, multiply, classify) feeds a 4-entry job queue;
// full rises when four items sit between the input and the back end.
// A 2-entry result queue lets the back end run while pop is low.
// Reset is asynchronous: all arrow pixels lit, row counter at zero.
// ----------------------------------------------------------------------------
module tilt_arrow_led_matrix_scanner_top
    import tals_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     req_type,
    input  logic [ADC_BITS-1:0]      sample_a,
    input  logic [ADC_BITS-1:0]      sample_b,
    output logic                     empty,
    input  logic                     pop,
    output logic [ROWS-1:0]          row_drive,
    output logic [COLS-1:0]          col_drive,
    output logic [2:0]               direction,
    output logic signed [TILT_W-1:0] tilt_x,
    output logic signed [TILT_W-1:0] tilt_y,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int JOB_CNT_W = $clog2(JOB_Q_DEPTH+1);
    localparam int RES_CNT_W = $clog2(RES_Q_DEPTH+1);

    logic                 job_wr, job_rd;
    job_t                 job_in, job_out;
    logic [JOB_CNT_W-1:0] job_count;
    q_stat_t              job_stat;

    logic                 res_wr;
    result_t              res_in, res_out;
    logic [RES_CNT_W-1:0] res_count;
    q_stat_t              res_stat;
    logic                 res_leaving;

    assign cfg_ready = 1'b1;

    tals_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .sample_a  (sample_a),
        .sample_b  (sample_b),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_count (job_count),
        .job_wr    (job_wr),
        .job       (job_in)
    );

    tals_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_Q_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (job_in),
        .rd_en   (job_rd),
        .rd_data (job_out),
        .count   (job_count),
        .stat    (job_stat)
    );

    tals_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_stat    (job_stat),
        .job         (job_out),
        .job_rd      (job_rd),
        .res_stat    (res_stat),
        .res_leaving (res_leaving),
        .res_wr      (res_wr),
        .res         (res_in)
    );

    assign res_leaving = pop && !res_stat.empty;

    tals_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .rd_en   (res_leaving),
        .rd_data (res_out),
        .count   (res_count),
        .stat    (res_stat)
    );

    assign empty     = (res_count == '0);
    assign row_drive = res_out.row_drive;
    assign col_drive = res_out.col_drive;
    assign direction = res_out.direction;
    assign tilt_x    = res_out.tilt_x;
    assign tilt_y    = res_out.tilt_y;

endmodule

// ===== sv/tals_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tals_checker
// Port-level checks on the scanner's results, bound to the top level.
// ----------------------------------------------------------------------------
module tals_checker
    import tals_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     empty,
    input logic                     pop,
    input logic [ROWS-1:0]          row_drive,
    input logic [COLS-1:0]          col_drive,
    input logic [2:0]               direction,
    input logic signed [TILT_W-1:0] tilt_x,
    input logic signed [TILT_W-1:0] tilt_y
);

    // at most one row line is driven
    a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $countones(~row_drive) <= 1)
        else $error("more than one row driven");

    // a scan item drives a row and reports no tilt
    a_tick_no_tilt: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && row_drive != 8'hFF) |-> (tilt_x == 4'sd0 && tilt_y == 4'sd0))
        else $error("tilt reported on scan item");

    // a sample item leaves all columns dark
    a_sample_cols_off: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && row_drive == 8'hFF) |-> col_drive == 8'hFF)
        else $error("columns driven without a row");

    // the only initial-pattern code is never reported for a sample
    a_sample_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && row_drive == 8'hFF) |-> direction < DIR_INIT)
        else $error("bad direction on sample item");

    // a waiting result's row and column drives hold until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(row_drive) && $stable(col_drive)))
        else $error("waiting result changed");

endmodule

bind tilt_arrow_led_matrix_scanner_top tals_checker u_tals_checker (.*);

// ===== tb/tals_scan_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tals_scan_checker
// Watches the item, result and register channels of the tilt arrow scanner,
// keeps its own copy of the frame, row counter and gains, predicts the drive
// of every accepted item and compares each popped result field by field.
// ----------------------------------------------------------------------------
module tals_scan_checker
    import tals_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic                     full,
    input  logic                     req_type,
    input  logic [ADC_BITS_DEF-1:0]  sample_a,
    input  logic [ADC_BITS_DEF-1:0]  sample_b,
    input  logic                     empty,
    input  logic                     pop,
    input  logic [ROWS-1:0]          row_drive,
    input  logic [COLS-1:0]          col_drive,
    input  logic [2:0]               direction,
    input  logic signed [TILT_W-1:0] tilt_x,
    input  logic signed [TILT_W-1:0] tilt_y,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       mismatch_count,
    output int                       results_due
);

    logic [MID_W-1:0]  zero_code;
    logic [GAIN_W-1:0] x_gain;
    logic [GAIN_W-1:0] y_gain;
    logic [COLS-1:0]   frame [ROWS];
    logic [ROW_W-1:0]  scan_ptr;
    dir_t              arrow_shown;
    result_t           due_drives [$];
    int                misses;

    // Q16 scale with truncation toward zero, clamped to the tilt range
    function automatic logic signed [TILT_W-1:0] tilt_of(
        input logic [ADC_BITS_DEF-1:0] code,
        input logic [MID_W-1:0]        mid,
        input logic [GAIN_W-1:0]       gain,
        input logic                    invert
    );
        int diff;
        int mag;
        int lvl;
        diff = int'(code) - int'(mid);
        mag = (diff < 0) ? -diff : diff;
        mag = (mag * int'(gain)) >>> Q_FRAC;
        if (mag > TILT_MAX)
            mag = TILT_MAX;
        lvl = (diff < 0) ? -mag : mag;
        if (invert)
            lvl = -lvl;
        return TILT_W'(lvl);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t                  want;
        logic signed [TILT_W-1:0] tx;
        logic signed [TILT_W-1:0] ty;
        int                       xi;
        int                       yi;
        dir_t                     d;
        logic [63:0]              glyph;
        logic [COLS-1:0]          pat;
        logic                     bad;
        if (!rst_n)
        begin
            zero_code = MID_RST;
            x_gain = GAIN_X_RST;
            y_gain = GAIN_Y_RST;
            for (int r = 0; r < ROWS; r++)
                frame[r] = 8'hFF;
            scan_ptr = '0;
            arrow_shown = DIR_INIT;
            due_drives.delete();
            misses = 0;
            mismatch_count <= 0;
            results_due <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (due_drives.size() == 0)
                begin
                    misses++;
                    if (misses <= 10)
                        $display("%0t: result with nothing due: row %h col %h dir %0d",
                                 $realtime, row_drive, col_drive, direction);
                end
                else
                begin
                    want = due_drives.pop_front();
                    bad = (row_drive !== want.row_drive) || (col_drive !== want.col_drive)
                        || (direction !== want.direction) || (tilt_x !== want.tilt_x)
                        || (tilt_y !== want.tilt_y);
                    if (bad)
                    begin
                        misses++;
                        if (misses <= 10)
                        begin
                            $write("%0t: mismatch (exp/got) row %h/%h col %h/%h",
                                   $realtime, want.row_drive, row_drive,
                                   want.col_drive, col_drive);
                            $display(" dir %0d/%0d tx %0d/%0d ty %0d/%0d",
                                     want.direction, direction, want.tilt_x, tilt_x,
                                     want.tilt_y, tilt_y);
                        end
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MID_CODE: zero_code = cfg_data[MID_W-1:0];
                    REG_GAIN_X:   x_gain = cfg_data[GAIN_W-1:0];
                    REG_GAIN_Y:   y_gain = cfg_data[GAIN_W-1:0];
                    default:      ;   // unmapped index: write dropped
                endcase
            end

            if (push && !full)
            begin
                if (req_type)
                begin
                    tx = tilt_of(sample_b, zero_code, x_gain, 1'b0);
                    ty = tilt_of(sample_a, zero_code, y_gain, 1'b1);
                    xi = tx;
                    yi = ty;
                    // sideways only when y leads x by more than one level
                    if (xi > 0)
                        d = (yi > xi + 1) ? DIR_RIGHT : (-yi > xi + 1) ? DIR_LEFT : DIR_FWD;
                    else if (xi < 0)
                        d = (yi > -(xi - 1)) ? DIR_RIGHT : (yi < xi - 1) ? DIR_LEFT : DIR_BACK;
                    else
                        d = (yi > 3) ? DIR_RIGHT : (yi < -3) ? DIR_LEFT : DIR_STOP;
                    case (d)
                        DIR_FWD:   glyph = 64'h18_3C_7E_FF_3C_3C_3C_3C;
                        DIR_BACK:  glyph = 64'h3C_3C_3C_3C_FF_7E_3C_18;
                        DIR_LEFT:  glyph = 64'h10_30_7F_FF_FF_7F_30_10;
                        DIR_RIGHT: glyph = 64'h08_0C_FE_FF_FF_FE_0C_08;
                        DIR_STOP:  glyph = 64'h3C_42_A1_91_89_85_42_3C;
                        default:   glyph = '1;
                    endcase
                    for (int r = 0; r < ROWS; r++)
                        frame[r] = glyph[63 - 8 * r -: 8];
                    arrow_shown = d;
                    want = '{row_drive: 8'hFF, col_drive: 8'hFF, direction: d,
                             tilt_x: tx, tilt_y: ty};
                end
                else
                begin
                    scan_ptr = scan_ptr + 1'b1;
                    pat = frame[scan_ptr];
                    for (int c = 0; c < COLS; c++)
                        want.col_drive[c] = ~pat[COLS - 1 - c];
                    want.row_drive = ~(8'd1 << scan_ptr);
                    want.direction = arrow_shown;
                    want.tilt_x = '0;
                    want.tilt_y = '0;
                end
                due_drives.push_back(want);
            end

            mismatch_count <= misses;
            results_due <= due_drives.size();
        end
    end

endmodule

// ===== tb/tb_tilt_arrow_led_matrix_scanner_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilt_arrow_led_matrix_scanner_top
// Drives scan ticks and accelerometer samples into the scanner under a run of
// gain and zero-code settings, with random stalls on both queue sides; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tilt_arrow_led_matrix_scanner_top;
    import tals_pkg::*;

    localparam int CODE_W   = ADC_BITS_DEF;
    localparam int CODE_MAX = (1 << CODE_W) - 1;
    localparam int N_PHASES = 7;
    localparam int PHASE_ITEMS = 70;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    logic                     req_type;
    logic [CODE_W-1:0]        sample_a;
    logic [CODE_W-1:0]        sample_b;
    logic                     empty;
    logic                     pop;
    logic [ROWS-1:0]          row_drive;
    logic [COLS-1:0]          col_drive;
    logic [2:0]               direction;
    logic signed [TILT_W-1:0] tilt_x;
    logic signed [TILT_W-1:0] tilt_y;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    int                       mismatch_count;
    int                       results_due;

    int send_idle_pct = 11;
    int recv_idle_pct = 87;
    int mid_now  = MID_RST;
    int gx_now   = GAIN_X_RST;
    int gy_now   = GAIN_Y_RST;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    tilt_arrow_led_matrix_scanner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .sample_a  (sample_a),
        .sample_b  (sample_b),
        .empty     (empty),
        .pop       (pop),
        .row_drive (row_drive),
        .col_drive (col_drive),
        .direction (direction),
        .tilt_x    (tilt_x),
        .tilt_y    (tilt_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tals_scan_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .sample_a       (sample_a),
        .sample_b       (sample_b),
        .empty          (empty),
        .pop            (pop),
        .row_drive      (row_drive),
        .col_drive      (col_drive),
        .direction      (direction),
        .tilt_x         (tilt_x),
        .tilt_y         (tilt_y),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // result side stalls
    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_item(input logic kind, input logic [CODE_W-1:0] a,
                             input logic [CODE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req_type <= kind;
        sample_a <= a;
        sample_b <= b;
        do @(posedge clk); while (full);
    endtask

    // step past the current edge first so the item taken at it is counted
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // gains carry junk in the bits above the register width
    task automatic configure(input logic poke_unused);
        write_reg(REG_MID_CODE, CFG_DATA_W'(mid_now));
        write_reg(REG_GAIN_X, CFG_DATA_W'(gx_now) | (CFG_DATA_W'($urandom_range(15)) << GAIN_W));
        write_reg(REG_GAIN_Y, CFG_DATA_W'(gy_now) | (CFG_DATA_W'($urandom_range(15)) << GAIN_W));
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // code within about nine tilt levels of the zero code
    function automatic logic [CODE_W-1:0] near_code(input int mid, input int gain);
        int span;
        int code;
        span = (gain == 0) ? CODE_MAX : (9 << Q_FRAC) / gain;
        if (span > CODE_MAX)
            span = CODE_MAX;
        code = mid - span + int'($urandom_range(2 * span));
        if (code < 0)
            code = 0;
        if (code > CODE_MAX)
            code = CODE_MAX;
        return CODE_W'(code);
    endfunction

    initial
    begin
        logic [CODE_W-1:0] m;
        int                pick;
        push <= 1'b0;
        req_type <= REQ_TICK;
        sample_a <= '0;
        sample_b <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MID_CODE;
        cfg_data <= '0;
        rst_n <= 1'b0;
        m = MID_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        repeat (2) push_item(REQ_TICK, '0, CODE_W'(CODE_MAX));    // all-lit start frame
        push_item(REQ_SAMPLE, m, m);                              // dead level
        repeat (9) push_item(REQ_TICK, CODE_W'(CODE_MAX), '0);    // whole glyph, row wrap
        push_item(REQ_SAMPLE, '0, m);
        push_item(REQ_SAMPLE, CODE_W'(CODE_MAX), m);
        push_item(REQ_SAMPLE, '0, CODE_W'(CODE_MAX));
        push_item(REQ_SAMPLE, CODE_W'(CODE_MAX), '0);
        // one-level thresholds; negative side truncates toward zero
        push_item(REQ_SAMPLE, m, m + 14'd199);
        push_item(REQ_SAMPLE, m, m - 14'd199);
        push_item(REQ_SAMPLE, m, m + 14'd198);
        push_item(REQ_SAMPLE, m + 14'd200, m - 14'd198);
        push_item(REQ_SAMPLE, CODE_W'(CODE_MAX), CODE_W'(CODE_MAX));
        push_item(REQ_SAMPLE, '0, '0);
        repeat (2) push_item(REQ_TICK, CODE_W'($urandom), CODE_W'($urandom));

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p * 3 / N_PHASES)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p > 0)
            begin
                wait_drained();
                case (p)
                    1:
                    begin
                        mid_now = 0;
                        gx_now = 1023;
                        gy_now = 1023;
                    end
                    2:
                    begin
                        mid_now = CODE_MAX;
                        gx_now = 0;
                        gy_now = 0;
                    end
                    3:
                    begin
                        mid_now = $urandom_range(CODE_MAX);
                        gx_now = 0;
                        gy_now = $urandom_range(1023, 1);
                    end
                    N_PHASES - 1:
                    begin
                        mid_now = MID_RST;
                        gx_now = GAIN_X_RST;
                        gy_now = GAIN_Y_RST;
                    end
                    default:
                    begin
                        mid_now = $urandom_range(CODE_MAX);
                        gx_now = $urandom_range(1023, 1);
                        gy_now = $urandom_range(1023, 1);
                    end
                endcase
                configure(p == 4);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    push_item(REQ_TICK, CODE_W'($urandom), CODE_W'($urandom));
                else if (pick < 85)
                    push_item(REQ_SAMPLE, near_code(mid_now, gy_now), near_code(mid_now, gx_now));
                else
                    push_item(REQ_SAMPLE, CODE_W'($urandom), CODE_W'($urandom));
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
